// ===== design/mpe_pkg.sv =====
// Shared types, register codes and helper functions for the escape-time pixel engine.
// No dependencies; used by mpe_cfg_regs, mpe_mul_unit and mandelbrot_pixel_engine.
`timescale 1ns / 1ps
`default_nettype none

package mpe_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_REAL_START = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_REAL_STEP  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAG_START = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAG_STEP  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_ITER_LIMIT = 3'd4;

    // Register reset values (Q4.28 for the coordinate registers).
    localparam logic [31:0] RST_REAL_START = 32'hD800_0000; // -2.5
    localparam logic [31:0] RST_REAL_STEP  = 32'd671089;
    localparam logic [31:0] RST_IMAG_START = 32'hF000_0000; // -1.0
    localparam logic [31:0] RST_IMAG_STEP  = 32'd671089;
    localparam logic [15:0] RST_ITER_LIMIT = 16'd10000;

    // Bailout threshold 4.0 in Q.28.
    localparam logic [36:0] FOUR_Q28 = 37'h0_4000_0000;

    // Reciprocal of ten for 16-bit operands: x / 10 == (x * 52429) >> 19.
    localparam logic [31:0] DIV10_MUL   = 32'd52429;
    localparam int unsigned DIV10_SHIFT = 19;

    // Configuration register set.
    typedef struct packed {
        logic [31:0] real_start;
        logic [31:0] real_step;
        logic [31:0] imag_start;
        logic [31:0] imag_step;
        logic [15:0] iteration_limit;
    } t_cfg;

    // Operand pairs for the shared multiplier unit (two's complement).
    typedef struct packed {
        logic [31:0] a0;
        logic [31:0] b0;
        logic [31:0] a1;
        logic [31:0] b1;
        logic [31:0] a2;
        logic [31:0] b2;
    } t_mul_ops;

    // Registered full-width products of the shared multiplier unit.
    typedef struct packed {
        logic [63:0] p0;
        logic [63:0] p1;
        logic [63:0] p2;
    } t_mul_prods;

    // Saturate a signed 45-bit value to the signed Q4.28 range.
    function automatic logic [31:0] sat_q(input logic [44:0] v);
        logic [31:0] res;
        if (!v[44] && (v[43:31] != 13'h0000)) begin
            res = 32'h7FFF_FFFF;
        end else if (v[44] && (v[43:31] != 13'h1FFF)) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // Remainder by ten from the operand and its quotient: x - 10 * q.
    function automatic logic [3:0] rem10(input logic [15:0] x, input logic [12:0] q);
        logic [15:0] q10;
        logic [15:0] diff;
        q10  = {q, 3'b000} + {2'b00, q, 1'b0};
        diff = x - q10;
        return diff[3:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/mandelbrot_pixel_engine.sv =====
// Escape-time pixel engine: one pixel word in, one count and color word out.
// A pixel is accepted only in the idle state, and the next one only after the previous result
// has been loaded into the output register. Each z step passes the shared multiplier unit's
// product register (S_MUL), then add, saturate and bailout compare (S_STEP).
// Synchronous active-low reset restores the register defaults and empties the engine.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_pixel_engine #(
    parameter int unsigned IMAGE_WIDTH = 1440
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [mpe_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [31:0]                     i_cfg_wdata,
    // Pixel input channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [10:0]                     i_pixel_x,
    input  wire logic [10:0]                     i_pixel_y,
    // Result output channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [21:0]                          o_pixel_index,
    output logic [15:0]                          o_escape_count,
    output logic                                 o_inside_set,
    output logic [3:0]                           o_red_level,
    output logic [3:0]                           o_green_level,
    output logic [3:0]                           o_blue_level
);

    // Sequencer states.
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MAP    = 8'b0000_0010,
        S_SEED   = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_STEP   = 8'b0001_0000,
        S_COLOR  = 8'b0010_0000,
        S_FINISH = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    localparam logic [31:0] WIDTH_OP = 32'(IMAGE_WIDTH);

    mpe_pkg::t_cfg       cfg;
    mpe_pkg::t_mul_ops   mul_ops;
    mpe_pkg::t_mul_prods mul_prods;

    t_state      r_state, n_state;
    logic [10:0] r_px, r_py;
    logic [31:0] r_cr, n_cr;
    logic [31:0] r_ci, n_ci;
    logic [31:0] r_zr, n_zr;
    logic [31:0] r_zi, n_zi;
    logic [15:0] r_n, n_n;
    logic [21:0] r_idx, n_idx;
    logic        r_inside, n_inside;
    logic [3:0]  r_red, n_red;
    logic [3:0]  r_green, n_green;
    logic [3:0]  r_blue, n_blue;
    logic        r_out_valid, n_out_valid;
    logic [21:0] r_out_idx;
    logic [15:0] r_out_count;
    logic        r_out_inside;
    logic [3:0]  r_out_red, r_out_green, r_out_blue;

    logic        in_fire;
    logic        out_free;
    logic [44:0] map_r_sum, map_i_sum;
    logic [35:0] rr, ii;
    logic [36:0] ri;
    logic [36:0] mag;
    logic        bail;
    logic [44:0] step_r_sum, step_i_sum;
    logic [12:0] q_blue, q_green, q_red;
    logic [15:0] n_half, n_quarter;

    mpe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    mpe_mul_unit u_mul (
        .i_clk   (i_clk),
        .i_ops   (mul_ops),
        .o_prods (mul_prods)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    // Operand selection for the shared multiplier unit.
    always_comb begin
        mul_ops = '0;
        unique case (r_state)
            S_MAP: begin
                mul_ops.a0 = {21'd0, r_px};
                mul_ops.b0 = cfg.real_step;
                mul_ops.a1 = {21'd0, r_py};
                mul_ops.b1 = cfg.imag_step;
                mul_ops.a2 = {21'd0, r_py};
                mul_ops.b2 = WIDTH_OP;
            end
            S_MUL: begin
                mul_ops.a0 = r_zr;
                mul_ops.b0 = r_zr;
                mul_ops.a1 = r_zi;
                mul_ops.b1 = r_zi;
                mul_ops.a2 = r_zr;
                mul_ops.b2 = r_zi;
            end
            S_COLOR: begin
                mul_ops.a0 = {16'd0, r_n};
                mul_ops.b0 = mpe_pkg::DIV10_MUL;
                mul_ops.a1 = {17'd0, r_n[15:1]};
                mul_ops.b1 = mpe_pkg::DIV10_MUL;
                mul_ops.a2 = {18'd0, r_n[15:2]};
                mul_ops.b2 = mpe_pkg::DIV10_MUL;
            end
            default: mul_ops = '0;
        endcase
    end

    // Point mapping: start plus coordinate times step, before saturation.
    assign map_r_sum = {{13{cfg.real_start[31]}}, cfg.real_start}
                     + {mul_prods.p0[43], mul_prods.p0[43:0]};
    assign map_i_sum = {{13{cfg.imag_start[31]}}, cfg.imag_start}
                     + {mul_prods.p1[43], mul_prods.p1[43:0]};

    // One z step: floor-shifted squares and cross term, bailout compare, next z.
    assign rr   = mul_prods.p0[63:28];
    assign ii   = mul_prods.p1[63:28];
    assign ri   = mul_prods.p2[63:27];
    assign mag  = {rr[35], rr} + {ii[35], ii};
    assign bail = !mag[36] && (mag >= mpe_pkg::FOUR_Q28);
    assign step_r_sum = {{9{rr[35]}}, rr} - {{9{ii[35]}}, ii}
                      + {{13{r_cr[31]}}, r_cr};
    assign step_i_sum = {{8{ri[36]}}, ri} + {{13{r_ci[31]}}, r_ci};

    // Quotients by ten of the count, the count over two and the count over four.
    assign q_blue    = mul_prods.p0[31:19];
    assign q_green   = mul_prods.p1[31:19];
    assign q_red     = mul_prods.p2[31:19];
    assign n_half    = {1'b0, r_n[15:1]};
    assign n_quarter = {2'b00, r_n[15:2]};

    // Sequencer and datapath next values.
    always_comb begin
        n_state     = r_state;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_zr        = r_zr;
        n_zi        = r_zi;
        n_n         = r_n;
        n_idx       = r_idx;
        n_inside    = r_inside;
        n_red       = r_red;
        n_green     = r_green;
        n_blue      = r_blue;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_SEED;
            end
            S_SEED: begin
                n_cr    = mpe_pkg::sat_q(map_r_sum);
                n_ci    = mpe_pkg::sat_q(map_i_sum);
                n_idx   = mul_prods.p2[21:0] + {11'd0, r_px};
                n_zr    = '0;
                n_zi    = '0;
                n_n     = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_STEP;
            end
            S_STEP: begin
                if (bail || (r_n >= cfg.iteration_limit)) begin
                    n_inside = (r_n >= cfg.iteration_limit);
                    n_state  = S_COLOR;
                end else begin
                    n_zr    = mpe_pkg::sat_q(step_r_sum);
                    n_zi    = mpe_pkg::sat_q(step_i_sum);
                    n_n     = r_n + 16'd1;
                    n_state = S_MUL;
                end
            end
            S_COLOR: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (r_inside) begin
                    n_blue  = '0;
                    n_green = '0;
                    n_red   = '0;
                end else begin
                    n_blue  = mpe_pkg::rem10(r_n, q_blue);
                    n_green = mpe_pkg::rem10(n_half, q_green);
                    n_red   = mpe_pkg::rem10(n_quarter, q_red);
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers of the current pixel.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
        end
        r_cr     <= n_cr;
        r_ci     <= n_ci;
        r_zr     <= n_zr;
        r_zi     <= n_zi;
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_inside <= n_inside;
        r_red    <= n_red;
        r_green  <= n_green;
        r_blue   <= n_blue;
    end

    // Output word register; loaded when the finished pixel leaves the engine.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_idx    <= r_idx;
            r_out_count  <= r_n;
            r_out_inside <= r_inside;
            r_out_red    <= r_red;
            r_out_green  <= r_green;
            r_out_blue   <= r_blue;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_index  = r_out_idx;
    assign o_escape_count = r_out_count;
    assign o_inside_set   = r_out_inside;
    assign o_red_level    = r_out_red;
    assign o_green_level  = r_out_green;
    assign o_blue_level   = r_out_blue;

    // An accepted word always starts the mapping step.
    a_accept_maps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == S_MAP))
        else $error("accepted pixel did not enter the mapping step");

    // The step state only ever consumes products launched in the previous cycle.
    a_step_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> ($past(r_state) == S_MUL))
        else $error("z step without a preceding multiply");

    // Pixels inside the set are shown black.
    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_inside_set) |->
            ((o_red_level == 4'd0) && (o_green_level == 4'd0) && (o_blue_level == 4'd0)))
        else $error("inside pixel carries a nonzero color");

    // Color levels are remainders by ten and never exceed nine.
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((o_red_level <= 4'd9) && (o_green_level <= 4'd9) && (o_blue_level <= 4'd9)))
        else $error("color level out of range");

    // A result is only presented after the engine has returned to idle.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ((r_state == S_IDLE) && ($past(r_state) == S_DONE)))
        else $error("result presented outside the done step");

endmodule

`default_nettype wire

// ===== design/mpe_cfg_regs.sv =====
// Configuration register file of the escape-time pixel engine.
// Depends on mpe_pkg for the register codes, reset values and the t_cfg type.
`timescale 1ns / 1ps
`default_nettype none

module mpe_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [mpe_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [31:0]                     i_cfg_wdata,
    output mpe_pkg::t_cfg                        o_cfg
);

    mpe_pkg::t_cfg r_cfg;
    mpe_pkg::t_cfg n_cfg;

    // Address decode; writes to indexes beyond the list are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                mpe_pkg::REG_REAL_START: n_cfg.real_start      = i_cfg_wdata;
                mpe_pkg::REG_REAL_STEP:  n_cfg.real_step       = i_cfg_wdata;
                mpe_pkg::REG_IMAG_START: n_cfg.imag_start      = i_cfg_wdata;
                mpe_pkg::REG_IMAG_STEP:  n_cfg.imag_step       = i_cfg_wdata;
                mpe_pkg::REG_ITER_LIMIT: n_cfg.iteration_limit = i_cfg_wdata[15:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    // Register storage with the documented reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_start      <= mpe_pkg::RST_REAL_START;
            r_cfg.real_step       <= mpe_pkg::RST_REAL_STEP;
            r_cfg.imag_start      <= mpe_pkg::RST_IMAG_START;
            r_cfg.imag_step       <= mpe_pkg::RST_IMAG_STEP;
            r_cfg.iteration_limit <= mpe_pkg::RST_ITER_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== design/mpe_mul_unit.sv =====
// Shared multiplier unit: three signed 32x32 multipliers with registered 64-bit products.
// Depends on mpe_pkg for the operand and product structs.
`timescale 1ns / 1ps
`default_nettype none

module mpe_mul_unit (
    input  wire logic           i_clk,
    input  mpe_pkg::t_mul_ops   i_ops,
    output mpe_pkg::t_mul_prods o_prods
);

    mpe_pkg::t_mul_prods r_prods;
    mpe_pkg::t_mul_prods n_prods;

    // Three independent signed products, one per operand pair.
    always_comb begin
        n_prods.p0 = $signed(i_ops.a0) * $signed(i_ops.b0);
        n_prods.p1 = $signed(i_ops.a1) * $signed(i_ops.b1);
        n_prods.p2 = $signed(i_ops.a2) * $signed(i_ops.b2);
    end

    // Product register; the consumer reads it in the cycle after the operands.
    always_ff @(posedge i_clk) begin
        r_prods <= n_prods;
    end

    assign o_prods = r_prods;

endmodule

`default_nettype wire
